// ----- rtl/tilt_pkg.sv -----
// ----------------------------------------------------------------------------
// tilt_pkg
// Shared widths, CORDIC angle table and pipeline bundle types.
// ----------------------------------------------------------------------------
package tilt_pkg;

	localparam int AXIS_W            = 16;
	localparam int TILT_W            = 16;
	localparam int THR_W             = 32;
	localparam int SQ_W              = 2 * AXIS_W - 1;
	localparam int PRE_SHIFT         = 8;
	localparam int XY_W              = AXIS_W + PRE_SHIFT + 3;
	localparam int ACC_W             = 32;
	localparam int ATAN_ENTRIES      = 24;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(4194304);
	localparam logic [ACC_W-1:0] HALF_TURN = ACC_W'(32'h8000_0000);
	localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (ACC_W - TILT_W - 1);

	// atan(2^-i) scaled so that pi is 2^31
	localparam logic [ACC_W-1:0] ATAN_STEPS [0:ATAN_ENTRIES-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef struct packed {
		logic [XY_W-1:0]  x;
		logic [XY_W-1:0]  y;
		logic [ACC_W-1:0] acc;
	} cordic_t;

	typedef struct packed {
		logic vld;
		logic ok;
		logic zero;
	} tag_t;

endpackage

// ----- rtl/tilt_front.sv -----
// ----------------------------------------------------------------------------
// tilt_front
// Half-plane pre-rotation, scaling and squared-magnitude threshold check.
// ----------------------------------------------------------------------------
module tilt_front import tilt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [AXIS_W-1:0] axis_a,
	input  logic [AXIS_W-1:0] axis_b,
	input  logic [THR_W-1:0]  thr,
	output cordic_t           q,
	output tag_t              q_tag
);

	logic signed [XY_W-1:0]     a_ext;
	logic signed [XY_W-1:0]     b_ext;
	logic signed [XY_W-1:0]     x0;
	logic signed [XY_W-1:0]     y0;
	logic signed [2*AXIS_W-1:0] prod_a;
	logic signed [2*AXIS_W-1:0] prod_b;
	logic [THR_W-1:0]           mag;

	cordic_t          rot_s1;
	logic [SQ_W-1:0]  sq_a_s1;
	logic [SQ_W-1:0]  sq_b_s1;
	logic             vld_s1;
	logic             zero_s1;
	cordic_t          rot_s2;
	logic             vld_s2;
	logic             ok_s2;
	logic             zero_s2;

	assign a_ext  = XY_W'($signed(axis_a));
	assign b_ext  = XY_W'($signed(axis_b));
	assign x0     = axis_a[AXIS_W-1] ? -a_ext : a_ext;
	assign y0     = axis_a[AXIS_W-1] ? -b_ext : b_ext;
	assign prod_a = $signed(axis_a) * $signed(axis_a);
	assign prod_b = $signed(axis_b) * $signed(axis_b);
	assign mag    = THR_W'(sq_a_s1) + THR_W'(sq_b_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1.x   <= x0 <<< PRE_SHIFT;
			rot_s1.y   <= y0 <<< PRE_SHIFT;
			rot_s1.acc <= axis_a[AXIS_W-1] ? HALF_TURN : '0;
			sq_a_s1    <= prod_a[SQ_W-1:0];
			sq_b_s1    <= prod_b[SQ_W-1:0];
			zero_s1    <= (axis_a == '0) && (axis_b == '0);
			rot_s2     <= rot_s1;
			ok_s2      <= mag >= thr;
			zero_s2    <= zero_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign q     = rot_s2;
	assign q_tag = '{vld: vld_s2, ok: ok_s2, zero: zero_s2};

endmodule

// ----- rtl/tilt_cell.sv -----
// ----------------------------------------------------------------------------
// tilt_cell
// One vectoring CORDIC micro-rotation with its output register.
// ----------------------------------------------------------------------------
module tilt_cell import tilt_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  cordic_t d,
	input  tag_t    d_tag,
	output cordic_t q,
	output tag_t    q_tag
);

	localparam logic [ACC_W-1:0] STEP = ATAN_STEPS[STAGE];

	logic signed [XY_W-1:0] xi;
	logic signed [XY_W-1:0] yi;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic                   y_neg;

	cordic_t data_s1;
	logic    vld_s1;
	logic    ok_s1;
	logic    zero_s1;

	assign xi    = $signed(d.x);
	assign yi    = $signed(d.y);
	assign xs    = xi >>> STAGE;
	assign ys    = yi >>> STAGE;
	assign y_neg = d.y[XY_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_neg) begin
				data_s1.x   <= xi - ys;
				data_s1.y   <= yi + xs;
				data_s1.acc <= d.acc - STEP;
			end else begin
				data_s1.x   <= xi + ys;
				data_s1.y   <= yi - xs;
				data_s1.acc <= d.acc + STEP;
			end
			ok_s1   <= d_tag.ok;
			zero_s1 <= d_tag.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d_tag.vld;
		end
	end

	assign q     = data_s1;
	assign q_tag = '{vld: vld_s1, ok: ok_s1, zero: zero_s1};

endmodule

// ----- rtl/tilt_angle_atan2_core.sv -----
// ----------------------------------------------------------------------------
// tilt_angle_atan2_core
// Tilt angle atan2(axis_b, axis_a) of a two-axis reading, pipelined CORDIC.
// ----------------------------------------------------------------------------
// Input beats (axis_a, axis_b) arrive on in_valid/in_ready; each gives one
// output beat (tilt, tilt_valid) on out_valid/out_ready. tilt is a binary
// angle, 32768 = pi; it is 0 whenever tilt_valid is low, i.e. when
// axis_a^2 + axis_b^2 is below the threshold written on cfg_valid/cfg_data.
// cfg_ready is always high; write the threshold only while the core is idle.
// Pipeline: two front stages, one register per CORDIC cell and one output
// register. Throughput: one beat per cycle; the cell chain advances every
// cycle unless the output side stalls.
// A stalled receiver fills a one-entry skid register behind the output
// register; in_ready depends only on that skid register, so out_ready has
// no combinational path to in_ready. While it is full the chain freezes.
// Reset empties the pipeline and loads the threshold with 2048^2.
// ----------------------------------------------------------------------------
module tilt_angle_atan2_core import tilt_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [THR_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [AXIS_W-1:0] axis_a,
	input  logic [AXIS_W-1:0] axis_b,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TILT_W-1:0] tilt,
	output logic              tilt_valid
);

	cordic_t           chain [0:CORDIC_STAGES];
	tag_t              tags  [0:CORDIC_STAGES];
	logic [THR_W-1:0]  thr_q;
	logic              en;
	logic [ACC_W-1:0]  rnd;
	logic [TILT_W-1:0] tilt_nx;
	logic              ok_nx;
	logic              out_vld_q;
	logic [TILT_W-1:0] tilt_q;
	logic              ok_q;
	logic              skid_vld_q;
	logic [TILT_W-1:0] skid_tilt_q;
	logic              skid_ok_q;

	assign cfg_ready = 1'b1;
	assign en        = !skid_vld_q;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	tilt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.axis_a (axis_a),
		.axis_b (axis_b),
		.thr    (thr_q),
		.q      (chain[0]),
		.q_tag  (tags[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		tilt_cell #(.STAGE(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (chain[i]),
			.d_tag  (tags[i]),
			.q      (chain[i+1]),
			.q_tag  (tags[i+1])
		);
	end

	assign rnd     = chain[CORDIC_STAGES].acc + ROUND_BIAS;
	assign ok_nx   = tags[CORDIC_STAGES].ok;
	assign tilt_nx = (ok_nx && !tags[CORDIC_STAGES].zero) ? rnd[ACC_W-1:ACC_W-TILT_W] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (out_vld_q && !out_ready) begin
				skid_vld_q <= tags[CORDIC_STAGES].vld;
			end else begin
				out_vld_q <= tags[CORDIC_STAGES].vld;
			end
		end else if (out_ready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_vld_q && !out_ready) begin
				skid_tilt_q <= tilt_nx;
				skid_ok_q   <= ok_nx;
			end else begin
				tilt_q <= tilt_nx;
				ok_q   <= ok_nx;
			end
		end else if (out_ready) begin
			tilt_q <= skid_tilt_q;
			ok_q   <= skid_ok_q;
		end
	end

	assign out_valid  = out_vld_q;
	assign tilt       = tilt_q;
	assign tilt_valid = ok_q;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register full while output register empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready))
		else $error("skid register filled without an output stall");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !tilt_valid) |-> (tilt == '0))
		else $error("nonzero tilt on an invalid beat");
`endif

endmodule
